@@ hdl/plc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the path location classifier: sizes, codes, needle table and helpers.
package plc_pkg;

    // Bytes of path visible to the matchers: the current byte plus the history.
    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_LEN      = HISTORY_DEPTH - 1;

    // Rows that take part in matching.
    localparam int ROW_COUNT   = 76;
    localparam int TABLE_ROWS  = 76;
    localparam int ACTIVE_ROWS = (ROW_COUNT < TABLE_ROWS) ? ROW_COUNT : TABLE_ROWS;

    // Row index reported when no row matched.
    localparam logic [6:0] NO_MATCH_ROW = 7'(ROW_COUNT);

    // Room for the longest needle, in bytes.
    localparam int TEXT_BYTES = 64;

    localparam logic [7:0] CH_UPPER_A  = "A";
    localparam logic [7:0] CH_UPPER_Z  = "Z";
    localparam logic [7:0] FOLD_OFFSET = 8'd32;
    localparam logic [7:0] CH_NUL      = 8'h00;

    typedef enum logic [4:0] {
        LOC_UNKNOWN,
        LOC_OTHER,
        LOC_SYS,
        LOC_PROG,
        LOC_TEMP,
        LOC_USER,
        LOC_AUTO,
        LOC_SVC,
        LOC_SCHED,
        LOC_SHINIT,
        LOC_PRELOAD,
        LOC_SSH,
        LOC_CRED,
        LOC_KMOD,
        LOC_WEB,
        LOC_HOSTS,
        LOC_PIPE
    } loc_t;

    typedef enum logic [4:0] {
        TECH_NONE,
        TECH_PIPE,
        TECH_RUN_KEY,
        TECH_STARTUP,
        TECH_LOGON_HOOK,
        TECH_ACCESS,
        TECH_ACTIVE_SETUP,
        TECH_XFER_JOB,
        TECH_PS_PROFILE,
        TECH_APPINIT,
        TECH_IFEO,
        TECH_SERVICE,
        TECH_SCHED_TASK,
        TECH_LD_PRELOAD,
        TECH_CRON,
        TECH_SYSTEMD,
        TECH_RC_SCRIPT,
        TECH_SH_PROFILE,
        TECH_SSH_KEY,
        TECH_ACCOUNT,
        TECH_SUDOERS,
        TECH_CRED_STORE,
        TECH_HOSTS,
        TECH_KMOD,
        TECH_WEB_SHELL
    } tech_t;

    // One needle row. The text is right aligned: its last character sits in bits 7:0.
    typedef struct packed {
        logic [TEXT_BYTES*8-1:0] text;
        loc_t                    loc;
        tech_t                   tech;
        logic                    fold;
    } pat_row_t;

    // Control from the input stage to the path tracker.
    typedef struct packed {
        logic fire;
        logic last;
    } step_ctl_t;

    // Everything the result stage needs about one finished path.
    typedef struct packed {
        logic                   seen;
        logic [ACTIVE_ROWS-1:0] hits;
    } path_sum_t;

    // Case-folded rows are written in lower case; folding makes that equivalent.
    localparam pat_row_t PAT_TABLE [TABLE_ROWS] = '{
        '{"\\device\\namedpipe\\", LOC_PIPE, TECH_PIPE, 1'b1},
        '{"\\pipe\\", LOC_PIPE, TECH_PIPE, 1'b1},
        '{"\\appdata\\local\\temp\\", LOC_TEMP, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\temp\\"}, LOC_TEMP, TECH_NONE, 1'b1},
        '{"\\appdat~1\\local~1\\temp\\", LOC_TEMP, TECH_NONE, 1'b1},
        '{"\\locals~1\\temp\\", LOC_TEMP, TECH_NONE, 1'b1},
        '{"/tmp/", LOC_TEMP, TECH_NONE, 1'b0},
        '{"/var/tmp/", LOC_TEMP, TECH_NONE, 1'b0},
        '{"/dev/shm/", LOC_TEMP, TECH_NONE, 1'b0},
        '{"\\currentversion\\run", LOC_AUTO, TECH_RUN_KEY, 1'b1},
        '{"\\currentversion\\runonce", LOC_AUTO, TECH_RUN_KEY, 1'b1},
        '{"\\start menu\\programs\\startup\\", LOC_AUTO, TECH_STARTUP, 1'b1},
        '{"/.config/autostart/", LOC_AUTO, TECH_STARTUP, 1'b0},
        '{"\\winlogon\\shell", LOC_AUTO, TECH_LOGON_HOOK, 1'b1},
        '{"\\currentversion\\accessibility\\ats\\", LOC_AUTO, TECH_ACCESS, 1'b1},
        '{"\\system32\\sethc.exe", LOC_AUTO, TECH_ACCESS, 1'b1},
        '{"\\system32\\utilman.exe", LOC_AUTO, TECH_ACCESS, 1'b1},
        '{"\\system32\\osk.exe", LOC_AUTO, TECH_ACCESS, 1'b1},
        '{"\\system32\\magnify.exe", LOC_AUTO, TECH_ACCESS, 1'b1},
        '{"\\active setup\\installed components\\", LOC_AUTO, TECH_ACTIVE_SETUP, 1'b1},
        '{{"\\micro", "soft\\network\\downloader\\"}, LOC_AUTO, TECH_XFER_JOB, 1'b1},
        '{{"\\win", "dows", "power", "shell\\micro", "soft.power", "shell_profile.ps1"},
          LOC_SHINIT, TECH_PS_PROFILE, 1'b1},
        '{{"\\win", "dows", "power", "shell\\profile.ps1"}, LOC_SHINIT, TECH_PS_PROFILE, 1'b1},
        '{{"\\documents\\power", "shell\\micro", "soft.power", "shell_profile.ps1"},
          LOC_SHINIT, TECH_PS_PROFILE, 1'b1},
        '{"\\winlogon\\userinit", LOC_AUTO, TECH_LOGON_HOOK, 1'b1},
        '{{"\\appinit", "_dlls"}, LOC_PRELOAD, TECH_APPINIT, 1'b1},
        '{"\\image file execution options\\", LOC_SVC, TECH_IFEO, 1'b1},
        '{"\\currentcontrolset\\services\\", LOC_SVC, TECH_SERVICE, 1'b1},
        '{"\\system32\\tasks\\", LOC_SCHED, TECH_SCHED_TASK, 1'b1},
        '{"\\schedule\\taskcache\\", LOC_SCHED, TECH_SCHED_TASK, 1'b1},
        '{"/etc/ld.so.preload", LOC_PRELOAD, TECH_LD_PRELOAD, 1'b0},
        '{"/etc/cron", LOC_SCHED, TECH_CRON, 1'b0},
        '{"/var/spool/cron", LOC_SCHED, TECH_CRON, 1'b0},
        '{"/etc/systemd/system/", LOC_SVC, TECH_SYSTEMD, 1'b0},
        '{"/lib/systemd/system/", LOC_SVC, TECH_SYSTEMD, 1'b0},
        '{"/.config/systemd/user/", LOC_SVC, TECH_SYSTEMD, 1'b0},
        '{"/etc/rc.local", LOC_SHINIT, TECH_RC_SCRIPT, 1'b0},
        '{"/etc/init.d/", LOC_SVC, TECH_RC_SCRIPT, 1'b0},
        '{"/.bashrc", LOC_SHINIT, TECH_SH_PROFILE, 1'b0},
        '{{"/.bash", "_profile"}, LOC_SHINIT, TECH_SH_PROFILE, 1'b0},
        '{"/.profile", LOC_SHINIT, TECH_SH_PROFILE, 1'b0},
        '{"/etc/profile", LOC_SHINIT, TECH_SH_PROFILE, 1'b0},
        '{{"/.ssh/authorized", "_keys"}, LOC_SSH, TECH_SSH_KEY, 1'b0},
        '{"/etc/passwd", LOC_CRED, TECH_ACCOUNT, 1'b0},
        '{"/etc/shadow", LOC_CRED, TECH_ACCOUNT, 1'b0},
        '{"/etc/sudoers", LOC_CRED, TECH_SUDOERS, 1'b0},
        '{"\\config\\sam", LOC_CRED, TECH_CRED_STORE, 1'b1},
        '{"\\config\\security", LOC_CRED, TECH_CRED_STORE, 1'b1},
        '{"\\config\\system", LOC_CRED, TECH_CRED_STORE, 1'b1},
        '{"\\drivers\\etc\\hosts", LOC_HOSTS, TECH_HOSTS, 1'b1},
        '{"/etc/hosts", LOC_HOSTS, TECH_HOSTS, 1'b0},
        '{"/lib/modules/", LOC_KMOD, TECH_KMOD, 1'b0},
        '{"\\system32\\drivers\\", LOC_KMOD, TECH_KMOD, 1'b1},
        '{"\\inetpub\\wwwroot\\", LOC_WEB, TECH_WEB_SHELL, 1'b1},
        '{"/var/www/", LOC_WEB, TECH_WEB_SHELL, 1'b0},
        '{{"\\win", "dows\\system32\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\syswow64\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\sychpe32\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\sysarm32\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\winsxs\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\assembly\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{{"\\win", "dows\\micro", "soft.net\\"}, LOC_SYS, TECH_NONE, 1'b1},
        '{"/usr/lib/", LOC_SYS, TECH_NONE, 1'b0},
        '{"/usr/lib64/", LOC_SYS, TECH_NONE, 1'b0},
        '{"/lib/", LOC_SYS, TECH_NONE, 1'b0},
        '{"/lib64/", LOC_SYS, TECH_NONE, 1'b0},
        '{"\\program files\\", LOC_PROG, TECH_NONE, 1'b1},
        '{"\\program files (x86)\\", LOC_PROG, TECH_NONE, 1'b1},
        '{"\\progra~1\\", LOC_PROG, TECH_NONE, 1'b1},
        '{"\\progra~2\\", LOC_PROG, TECH_NONE, 1'b1},
        '{"/usr/bin/", LOC_PROG, TECH_NONE, 1'b0},
        '{"/usr/sbin/", LOC_PROG, TECH_NONE, 1'b0},
        '{"/opt/", LOC_PROG, TECH_NONE, 1'b0},
        '{"\\users\\", LOC_USER, TECH_NONE, 1'b1},
        '{"/home/", LOC_USER, TECH_NONE, 1'b0},
        '{"/root/", LOC_USER, TECH_NONE, 1'b0}
    };

    // Folds A-Z to a-z; every other byte passes unchanged.
    function automatic logic [7:0] lower_az(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + FOLD_OFFSET : c;
    endfunction

    // Number of characters in a right-aligned needle (run of nonzero bytes from bit 0).
    function automatic int needle_len(input logic [TEXT_BYTES*8-1:0] text);
        int   n;
        logic gap;
        n   = 0;
        gap = 1'b0;
        for (int i = 0; i < TEXT_BYTES; i++)
        begin
            if (text[8*i +: 8] == CH_NUL)
                gap = 1'b1;
            else if (!gap)
                n = i + 1;
        end
        return n;
    endfunction

endpackage

@@ hdl/plc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for path bytes in and classification results out.
interface plc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       last_byte;

    modport source (output valid, output path_byte, output last_byte, input ready);
    modport sink   (input valid, input path_byte, input last_byte, output ready);
endinterface

interface plc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] location_class;
    logic [4:0] technique_code;
    logic [6:0] matched_row;

    modport source (output valid, output location_class, output technique_code,
                    output matched_row, input ready);
    modport sink   (input valid, input location_class, input technique_code,
                    input matched_row, output ready);
endinterface

@@ hdl/path_location_classifier_core.sv @@
`timescale 1ns / 1ps
// Top level of the path location classifier: input stage, path tracker and result stage.
//
//   Channel    Dir  Payload                                          Item
//   in_item    in   path_byte[7:0], last_byte                        one path byte
//   out_item   out  location_class[4:0], technique_code[4:0],        one result per path
//                   matched_row[6:0]
//
// One path byte is taken every cycle while no last byte waits for a summary slot.
// A byte is registered, then matched against all needle rows in parallel on the byte
// history in the next cycle; a path's result goes via the summary and output registers.
// Reset is asynchronous and active low; it empties the pipeline and clears path state.
// A stalled result holds in the output register while a second finished path waits in
// the summary register; only then does back pressure reach in_item.ready.
module path_location_classifier_core
(
    input  logic      clk,
    input  logic      rst_n,
    plc_in_if.sink    in_item,
    plc_out_if.source out_item
);

    // Input stage: one registered byte waiting to be matched.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               s1_last_reg;
    logic               s1_fire;
    logic               fin_ready;
    plc_pkg::step_ctl_t ctl;
    plc_pkg::path_sum_t summary;

    // A byte that does not end its path needs no room downstream; a last byte needs a
    // free summary slot, since its path state is cleared as it moves on.
    assign s1_fire       = s1_valid_reg && (!s1_last_reg || fin_ready);
    assign in_item.ready = !s1_valid_reg || s1_fire;
    assign s1_valid_next = in_item.valid || (s1_valid_reg && !s1_fire);

    assign ctl.fire = s1_fire;
    assign ctl.last = s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_item.ready)
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            s1_byte_reg <= in_item.path_byte;
            s1_last_reg <= in_item.last_byte;
        end
    end

    // Matching and per-path state.
    plc_path_track u_path_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .path_byte (s1_byte_reg),
        .summary   (summary)
    );

    // Priority pick and output register.
    plc_result u_result
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_fire && s1_last_reg),
        .summary   (summary),
        .fin_ready (fin_ready),
        .out_item  (out_item)
    );

endmodule

@@ hdl/plc_row_match.sv @@
`timescale 1ns / 1ps
// Parallel needle comparators: flags every row whose needle ends at the current byte.
module plc_row_match
(
    input  logic [7:0]                       cur_byte,
    input  logic [7:0]                       hist [plc_pkg::HIST_LEN],
    output logic [plc_pkg::ACTIVE_ROWS-1:0]  hits
);

    // Window position 0 is the current byte, position k is the k-th byte back.
    logic [7:0] win      [plc_pkg::HISTORY_DEPTH];
    logic [7:0] win_fold [plc_pkg::HISTORY_DEPTH];

    for (genvar k = 0; k < plc_pkg::HISTORY_DEPTH; k++)
    begin : g_win
        if (k == 0)
        begin : g_cur
            assign win[k] = cur_byte;
        end
        else
        begin : g_old
            assign win[k] = hist[k-1];
        end
        assign win_fold[k] = plc_pkg::lower_az(win[k]);
    end

    for (genvar r = 0; r < plc_pkg::ACTIVE_ROWS; r++)
    begin : g_row
        localparam int   LEN  = plc_pkg::needle_len(plc_pkg::PAT_TABLE[r].text);
        localparam logic FOLD = plc_pkg::PAT_TABLE[r].fold;

        if (LEN == 0 || LEN > plc_pkg::HISTORY_DEPTH)
        begin : g_never
            // An empty needle, or one that does not fit in the window, can never match.
            assign hits[r] = 1'b0;
        end
        else
        begin : g_cmp
            logic [LEN-1:0] eq;
            for (genvar k = 0; k < LEN; k++)
            begin : g_byte
                localparam logic [7:0] RAW = plc_pkg::PAT_TABLE[r].text[8*k +: 8];
                if (FOLD)
                begin : g_fold
                    assign eq[k] = (win_fold[k] == plc_pkg::lower_az(RAW));
                end
                else
                begin : g_exact
                    assign eq[k] = (win[k] == RAW);
                end
            end
            assign hits[r] = &eq;
        end
    end

endmodule

@@ hdl/plc_path_track.sv @@
`timescale 1ns / 1ps
// Per-path state: byte history, sticky row hits, end-of-path and non-empty flags.
module plc_path_track
(
    input  logic               clk,
    input  logic               rst_n,
    input  plc_pkg::step_ctl_t ctl,
    input  logic [7:0]         path_byte,
    output plc_pkg::path_sum_t summary
);

    logic [7:0]                      hist_reg  [plc_pkg::HIST_LEN];
    logic [7:0]                      hist_next [plc_pkg::HIST_LEN];
    logic [plc_pkg::ACTIVE_ROWS-1:0] row_hit_reg;
    logic [plc_pkg::ACTIVE_ROWS-1:0] row_hit_next;
    logic                            ended_reg;
    logic                            ended_next;
    logic                            seen_reg;
    logic                            seen_next;
    logic [plc_pkg::ACTIVE_ROWS-1:0] hits_now;
    logic                            take;

    plc_row_match u_row_match
    (
        .cur_byte (path_byte),
        .hist     (hist_reg),
        .hits     (hits_now)
    );

    // A byte counts only before the first zero byte of the path.
    assign take = ctl.fire && !ended_reg && (path_byte != plc_pkg::CH_NUL);

    assign summary.hits = row_hit_reg | (take ? hits_now : '0);
    assign summary.seen = seen_reg | take;

    always_comb
    begin
        hist_next    = hist_reg;
        row_hit_next = row_hit_reg;
        ended_next   = ended_reg;
        seen_next    = seen_reg;
        if (ctl.fire && ctl.last)
        begin
            for (int i = 0; i < plc_pkg::HIST_LEN; i++)
            begin
                hist_next[i] = plc_pkg::CH_NUL;
            end
            row_hit_next = '0;
            ended_next   = 1'b0;
            seen_next    = 1'b0;
        end
        else if (take)
        begin
            hist_next[0] = path_byte;
            for (int i = 1; i < plc_pkg::HIST_LEN; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
            row_hit_next = summary.hits;
            seen_next    = 1'b1;
        end
        else if (ctl.fire && path_byte == plc_pkg::CH_NUL)
        begin
            ended_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < plc_pkg::HIST_LEN; i++)
            begin
                hist_reg[i] <= plc_pkg::CH_NUL;
            end
            row_hit_reg <= '0;
            ended_reg   <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            hist_reg    <= hist_next;
            row_hit_reg <= row_hit_next;
            ended_reg   <= ended_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

@@ hdl/plc_result.sv @@
`timescale 1ns / 1ps
// Holds finished path summaries, picks the first hit row and drives the result channel.
module plc_result
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  plc_pkg::path_sum_t summary,
    output logic               fin_ready,
    plc_out_if.source          out_item
);

    logic               fin_valid_reg;
    logic               fin_valid_next;
    plc_pkg::path_sum_t fin_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    plc_pkg::loc_t      loc_reg;
    plc_pkg::loc_t      loc_next;
    plc_pkg::tech_t     tech_reg;
    plc_pkg::tech_t     tech_next;
    logic [6:0]         row_reg;
    logic [6:0]         row_next;
    logic               out_free;

    assign out_free       = !out_valid_reg || out_item.ready;
    assign fin_ready      = !fin_valid_reg || out_free;
    assign fin_valid_next = load || (fin_valid_reg && !out_free);
    assign out_valid_next = out_free ? fin_valid_reg : out_valid_reg;

    // First hit row in table order wins; scan from the back so the lowest index sticks.
    always_comb
    begin
        loc_next  = plc_pkg::LOC_UNKNOWN;
        tech_next = plc_pkg::TECH_NONE;
        row_next  = plc_pkg::NO_MATCH_ROW;
        if (fin_reg.seen)
        begin
            loc_next = plc_pkg::LOC_OTHER;
            for (int r = plc_pkg::ACTIVE_ROWS - 1; r >= 0; r--)
            begin
                if (fin_reg.hits[r])
                begin
                    loc_next  = plc_pkg::PAT_TABLE[r].loc;
                    tech_next = plc_pkg::PAT_TABLE[r].tech;
                    row_next  = 7'(r);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fin_reg <= summary;
        end
        if (out_free && fin_valid_reg)
        begin
            loc_reg  <= loc_next;
            tech_reg <= tech_next;
            row_reg  <= row_next;
        end
    end

    assign out_item.valid          = out_valid_reg;
    assign out_item.location_class = loc_reg;
    assign out_item.technique_code = tech_reg;
    assign out_item.matched_row    = row_reg;

endmodule

@@ hdl/plc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the classifier results, bound to the top level.
module plc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] location_class,
    input logic [4:0] technique_code,
    input logic [6:0] matched_row
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // An empty path reports no technique and no row.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && location_class == plc_pkg::LOC_UNKNOWN |->
            technique_code == plc_pkg::TECH_NONE && matched_row == plc_pkg::NO_MATCH_ROW)
        else $error("empty path reported a match");

    // A path with no hit reports no technique and no row.
    a_other: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && location_class == plc_pkg::LOC_OTHER |->
            technique_code == plc_pkg::TECH_NONE && matched_row == plc_pkg::NO_MATCH_ROW)
        else $error("unmatched path reported a technique or row");

    // A reported row always carries a table location class.
    a_row_loc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched_row != plc_pkg::NO_MATCH_ROW |->
            location_class != plc_pkg::LOC_UNKNOWN && location_class != plc_pkg::LOC_OTHER)
        else $error("matched row without a table location class");

endmodule

bind path_location_classifier_core plc_checker u_plc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_item.valid),
    .out_ready      (out_item.ready),
    .location_class (out_item.location_class),
    .technique_code (out_item.technique_code),
    .matched_row    (out_item.matched_row)
);

@@ tb/path_location_classifier_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the path location classifier: byte stream in, one class per path.
module path_location_classifier_core_tb;

    // The run is stopped here even if the block hangs; the limit is far above any correct run.
    localparam int CYCLE_LIMIT = 200000;

    // Least number of random bytes and of paths queued per idling phase.
    localparam int PHASE_BYTES = 160;
    localparam int PHASE_PATHS = 3;

    // Cycles allowed after the last expected result for a stray extra one.
    localparam int DRAIN_CYCLES = 8;

    // One byte of a path as the sender drives it.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } path_item_t;

    // The class expected for one finished path.
    typedef struct packed {
        plc_pkg::loc_t  loc;
        plc_pkg::tech_t tech;
        logic [6:0]     row;
    } path_class_t;

    // One row of the needle list, kept in its original mixed case so that
    // the case folding of the block is really exercised.
    typedef struct {
        string          text;
        plc_pkg::loc_t  loc;
        plc_pkg::tech_t tech;
        bit             fold;
    } needle_t;

    logic clk;
    logic rst_n;

    plc_in_if  in_item ();
    plc_out_if out_item ();

    path_location_classifier_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item)
    );

    needle_t     needles [$];
    path_item_t  pending_bytes [$];
    path_class_t expected_classes [$];

    // Predicted path state: recent bytes newest first, rows hit so far, whether
    // a zero byte ended the path and whether any real byte was taken.
    logic [7:0] recent_bytes [plc_pkg::HIST_LEN];
    bit         row_seen [plc_pkg::TABLE_ROWS];
    bit         zero_seen;
    bit         has_content;

    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned queued_bytes;
    int unsigned queued_paths;
    bit          byte_taken;

    // Clock and the single reset at the start of the run.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'd32;
        return c;
    endfunction

    task automatic add_needle(input string text, input plc_pkg::loc_t loc,
                              input plc_pkg::tech_t tech, input bit fold);
        needle_t n;
        n.text = text;
        n.loc  = loc;
        n.tech = tech;
        n.fold = fold;
        needles.push_back(n);
    endtask

    // The needle list in priority order. Some texts are built from pieces.
    task automatic load_needles();
        add_needle("\\Device\\NamedPipe\\", plc_pkg::LOC_PIPE, plc_pkg::TECH_PIPE, 1'b1);
        add_needle("\\pipe\\", plc_pkg::LOC_PIPE, plc_pkg::TECH_PIPE, 1'b1);
        add_needle("\\AppData\\Local\\Temp\\", plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\Temp\\"}, plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE, 1'b1);
        add_needle("\\APPDAT~1\\LOCAL~1\\Temp\\", plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE,
                   1'b1);
        add_needle("\\LOCALS~1\\Temp\\", plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE, 1'b1);
        add_needle("/tmp/", plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/var/tmp/", plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/dev/shm/", plc_pkg::LOC_TEMP, plc_pkg::TECH_NONE, 1'b0);
        add_needle("\\CurrentVersion\\Run", plc_pkg::LOC_AUTO, plc_pkg::TECH_RUN_KEY, 1'b1);
        add_needle("\\CurrentVersion\\RunOnce", plc_pkg::LOC_AUTO, plc_pkg::TECH_RUN_KEY,
                   1'b1);
        add_needle("\\Start Menu\\Programs\\Startup\\", plc_pkg::LOC_AUTO,
                   plc_pkg::TECH_STARTUP, 1'b1);
        add_needle("/.config/autostart/", plc_pkg::LOC_AUTO, plc_pkg::TECH_STARTUP, 1'b0);
        add_needle("\\Winlogon\\Shell", plc_pkg::LOC_AUTO, plc_pkg::TECH_LOGON_HOOK, 1'b1);
        add_needle("\\CurrentVersion\\Accessibility\\ATs\\", plc_pkg::LOC_AUTO,
                   plc_pkg::TECH_ACCESS, 1'b1);
        add_needle("\\System32\\sethc.exe", plc_pkg::LOC_AUTO, plc_pkg::TECH_ACCESS, 1'b1);
        add_needle("\\System32\\utilman.exe", plc_pkg::LOC_AUTO, plc_pkg::TECH_ACCESS, 1'b1);
        add_needle("\\System32\\osk.exe", plc_pkg::LOC_AUTO, plc_pkg::TECH_ACCESS, 1'b1);
        add_needle("\\System32\\Magnify.exe", plc_pkg::LOC_AUTO, plc_pkg::TECH_ACCESS, 1'b1);
        add_needle("\\Active Setup\\Installed Components\\", plc_pkg::LOC_AUTO,
                   plc_pkg::TECH_ACTIVE_SETUP, 1'b1);
        add_needle({"\\Micro", "soft\\Network\\Downloader\\"}, plc_pkg::LOC_AUTO,
                   plc_pkg::TECH_XFER_JOB, 1'b1);
        add_needle({"\\Win", "dowsPower", "Shell\\Micro", "soft.Power", "Shell_profile.ps1"},
                   plc_pkg::LOC_SHINIT, plc_pkg::TECH_PS_PROFILE, 1'b1);
        add_needle({"\\Win", "dowsPower", "Shell\\profile.ps1"}, plc_pkg::LOC_SHINIT,
                   plc_pkg::TECH_PS_PROFILE, 1'b1);
        add_needle({"\\Documents\\Power", "Shell\\Micro", "soft.Power", "Shell_profile.ps1"},
                   plc_pkg::LOC_SHINIT, plc_pkg::TECH_PS_PROFILE, 1'b1);
        add_needle("\\Winlogon\\Userinit", plc_pkg::LOC_AUTO, plc_pkg::TECH_LOGON_HOOK, 1'b1);
        add_needle({"\\AppInit", "_DLLs"}, plc_pkg::LOC_PRELOAD, plc_pkg::TECH_APPINIT, 1'b1);
        add_needle("\\Image File Execution Options\\", plc_pkg::LOC_SVC, plc_pkg::TECH_IFEO,
                   1'b1);
        add_needle("\\CurrentControlSet\\Services\\", plc_pkg::LOC_SVC,
                   plc_pkg::TECH_SERVICE, 1'b1);
        add_needle("\\System32\\Tasks\\", plc_pkg::LOC_SCHED, plc_pkg::TECH_SCHED_TASK, 1'b1);
        add_needle("\\Schedule\\TaskCache\\", plc_pkg::LOC_SCHED, plc_pkg::TECH_SCHED_TASK,
                   1'b1);
        add_needle("/etc/ld.so.preload", plc_pkg::LOC_PRELOAD, plc_pkg::TECH_LD_PRELOAD,
                   1'b0);
        add_needle("/etc/cron", plc_pkg::LOC_SCHED, plc_pkg::TECH_CRON, 1'b0);
        add_needle("/var/spool/cron", plc_pkg::LOC_SCHED, plc_pkg::TECH_CRON, 1'b0);
        add_needle("/etc/systemd/system/", plc_pkg::LOC_SVC, plc_pkg::TECH_SYSTEMD, 1'b0);
        add_needle("/lib/systemd/system/", plc_pkg::LOC_SVC, plc_pkg::TECH_SYSTEMD, 1'b0);
        add_needle("/.config/systemd/user/", plc_pkg::LOC_SVC, plc_pkg::TECH_SYSTEMD, 1'b0);
        add_needle("/etc/rc.local", plc_pkg::LOC_SHINIT, plc_pkg::TECH_RC_SCRIPT, 1'b0);
        add_needle("/etc/init.d/", plc_pkg::LOC_SVC, plc_pkg::TECH_RC_SCRIPT, 1'b0);
        add_needle("/.bashrc", plc_pkg::LOC_SHINIT, plc_pkg::TECH_SH_PROFILE, 1'b0);
        add_needle({"/.bash", "_profile"}, plc_pkg::LOC_SHINIT, plc_pkg::TECH_SH_PROFILE,
                   1'b0);
        add_needle("/.profile", plc_pkg::LOC_SHINIT, plc_pkg::TECH_SH_PROFILE, 1'b0);
        add_needle("/etc/profile", plc_pkg::LOC_SHINIT, plc_pkg::TECH_SH_PROFILE, 1'b0);
        add_needle({"/.ssh/authorized", "_keys"}, plc_pkg::LOC_SSH, plc_pkg::TECH_SSH_KEY,
                   1'b0);
        add_needle("/etc/passwd", plc_pkg::LOC_CRED, plc_pkg::TECH_ACCOUNT, 1'b0);
        add_needle("/etc/shadow", plc_pkg::LOC_CRED, plc_pkg::TECH_ACCOUNT, 1'b0);
        add_needle("/etc/sudoers", plc_pkg::LOC_CRED, plc_pkg::TECH_SUDOERS, 1'b0);
        add_needle("\\config\\SAM", plc_pkg::LOC_CRED, plc_pkg::TECH_CRED_STORE, 1'b1);
        add_needle("\\config\\SECURITY", plc_pkg::LOC_CRED, plc_pkg::TECH_CRED_STORE, 1'b1);
        add_needle("\\config\\SYSTEM", plc_pkg::LOC_CRED, plc_pkg::TECH_CRED_STORE, 1'b1);
        add_needle("\\drivers\\etc\\hosts", plc_pkg::LOC_HOSTS, plc_pkg::TECH_HOSTS, 1'b1);
        add_needle("/etc/hosts", plc_pkg::LOC_HOSTS, plc_pkg::TECH_HOSTS, 1'b0);
        add_needle("/lib/modules/", plc_pkg::LOC_KMOD, plc_pkg::TECH_KMOD, 1'b0);
        add_needle("\\System32\\drivers\\", plc_pkg::LOC_KMOD, plc_pkg::TECH_KMOD, 1'b1);
        add_needle("\\inetpub\\wwwroot\\", plc_pkg::LOC_WEB, plc_pkg::TECH_WEB_SHELL, 1'b1);
        add_needle("/var/www/", plc_pkg::LOC_WEB, plc_pkg::TECH_WEB_SHELL, 1'b0);
        add_needle({"\\Win", "dows\\System32\\"}, plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\SysWOW64\\"}, plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\SyChpe32\\"}, plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\SysArm32\\"}, plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\WinSxS\\"}, plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\assembly\\"}, plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b1);
        add_needle({"\\Win", "dows\\Micro", "soft.NET\\"}, plc_pkg::LOC_SYS,
                   plc_pkg::TECH_NONE, 1'b1);
        add_needle("/usr/lib/", plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/usr/lib64/", plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/lib/", plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/lib64/", plc_pkg::LOC_SYS, plc_pkg::TECH_NONE, 1'b0);
        add_needle("\\Program Files\\", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b1);
        add_needle("\\Program Files (x86)\\", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b1);
        add_needle("\\PROGRA~1\\", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b1);
        add_needle("\\PROGRA~2\\", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b1);
        add_needle("/usr/bin/", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/usr/sbin/", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/opt/", plc_pkg::LOC_PROG, plc_pkg::TECH_NONE, 1'b0);
        add_needle("\\Users\\", plc_pkg::LOC_USER, plc_pkg::TECH_NONE, 1'b1);
        add_needle("/home/", plc_pkg::LOC_USER, plc_pkg::TECH_NONE, 1'b0);
        add_needle("/root/", plc_pkg::LOC_USER, plc_pkg::TECH_NONE, 1'b0);
    endtask

    // True when the needle of row r ends exactly at byte c, looking back
    // through the held bytes. Folding applies to both sides on folded rows.
    function automatic bit needle_ends_at(input int r, input logic [7:0] c);
        int         len;
        logic [7:0] h;
        logic [7:0] n;
        len = needles[r].text.len();
        if (len == 0 || len > plc_pkg::HISTORY_DEPTH)
            return 1'b0;
        for (int k = 0; k < len; k++)
        begin
            h = (k == 0) ? c : recent_bytes[k - 1];
            n = needles[r].text[len - 1 - k];
            if (needles[r].fold)
            begin
                h = fold_case(h);
                n = fold_case(n);
            end
            if (h != n)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_path_state();
        foreach (recent_bytes[i])
            recent_bytes[i] = 8'h00;
        foreach (row_seen[i])
            row_seen[i] = 1'b0;
        zero_seen   = 1'b0;
        has_content = 1'b0;
    endtask

    // Updates the predicted path state with one accepted byte and, on the
    // marked last byte, queues the class the block must report.
    task automatic take_path_byte(input logic [7:0] c, input logic last);
        path_class_t cls;
        if (!zero_seen)
        begin
            if (c == 8'h00)
                zero_seen = 1'b1;
            else
            begin
                for (int r = 0; r < plc_pkg::ACTIVE_ROWS; r++)
                    if (needle_ends_at(r, c))
                        row_seen[r] = 1'b1;
                for (int k = plc_pkg::HIST_LEN - 1; k > 0; k--)
                    recent_bytes[k] = recent_bytes[k - 1];
                recent_bytes[0] = c;
                has_content     = 1'b1;
            end
        end
        if (last)
        begin
            cls.loc  = plc_pkg::LOC_UNKNOWN;
            cls.tech = plc_pkg::TECH_NONE;
            cls.row  = plc_pkg::NO_MATCH_ROW;
            if (has_content)
            begin
                cls.loc = plc_pkg::LOC_OTHER;
                // Walk downward so that the first hit row in list order wins.
                for (int r = plc_pkg::ACTIVE_ROWS - 1; r >= 0; r--)
                begin
                    if (row_seen[r])
                    begin
                        cls.loc  = needles[r].loc;
                        cls.tech = needles[r].tech;
                        cls.row  = 7'(r);
                    end
                end
            end
            expected_classes.push_back(cls);
            clear_path_state();
        end
    endtask

    task automatic queue_byte(input logic [7:0] value, input logic last);
        path_item_t item;
        item.value = value;
        item.last  = last;
        pending_bytes.push_back(item);
        queued_bytes++;
        if (last)
            queued_paths++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], i == s.len() - 1);
    endtask

    // Filler byte: mostly characters seen in real paths, sometimes any nonzero value.
    function automatic logic [7:0] filler_byte();
        string alphabet;
        alphabet = "/\\abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._~- ";
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(1, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    // Builds one random path. Most paths carry one or two needles with random
    // case changes and random filler around them; some needles are cut short,
    // some paths are long enough to push bytes out of the history, and a few
    // are raw noise over the whole byte range or hold an embedded zero.
    task automatic queue_random_path();
        logic [7:0] text [$];
        int         kind;
        int         r;
        int         len;
        bit         mangle;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 88)
        begin
            repeat ((kind >= 76) ? $urandom_range(40, 70) : $urandom_range(0, 10))
                text.push_back(filler_byte());
            repeat ($urandom_range(1, 2))
            begin
                r      = $urandom_range(0, needles.size() - 1);
                len    = needles[r].text.len();
                // Case changes on an unfolded row must defeat the match, so keep them rare.
                mangle = needles[r].fold || ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 9) == 0)
                    len = len - 1;
                for (int i = 0; i < len; i++)
                begin
                    c = needles[r].text[i];
                    if (mangle && fold_case(c) >= "a" && fold_case(c) <= "z"
                        && $urandom_range(0, 1) == 1)
                        c = c ^ 8'h20;
                    text.push_back(c);
                end
                repeat ($urandom_range(0, 6))
                    text.push_back(filler_byte());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                text.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            text.insert($urandom_range(0, text.size()), 8'h00);
        if (text.size() == 0)
            text.push_back(filler_byte());
        foreach (text[i])
            queue_byte(text[i], i == text.size() - 1);
    endtask

    // Cycle counter and the hard stop.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Monitor: at each rising edge, an accepted path byte goes to the
    // predictor and an accepted result is checked against the oldest
    // expected class. The predictor runs first, so a result could never
    // overtake its own path byte here.
    always @(posedge clk)
    begin
        path_class_t want;
        if (!rst_n)
            byte_taken <= 1'b0;
        else
        begin
            byte_taken <= in_item.valid && in_item.ready;
            if (in_item.valid && in_item.ready)
                take_path_byte(in_item.path_byte, in_item.last_byte);
            if (out_item.valid && out_item.ready)
            begin
                if (expected_classes.size() == 0)
                begin
                    $display("%0t: result with no path pending: loc %0d tech %0d row %0d",
                             $time, out_item.location_class, out_item.technique_code,
                             out_item.matched_row);
                    error_count++;
                end
                else
                begin
                    want = expected_classes.pop_front();
                    if (out_item.location_class !== want.loc)
                    begin
                        $display("%0t: location_class expected %0d actual %0d",
                                 $time, want.loc, out_item.location_class);
                        error_count++;
                    end
                    if (out_item.technique_code !== want.tech)
                    begin
                        $display("%0t: technique_code expected %0d actual %0d",
                                 $time, want.tech, out_item.technique_code);
                        error_count++;
                    end
                    if (out_item.matched_row !== want.row)
                    begin
                        $display("%0t: matched_row expected %0d actual %0d",
                                 $time, want.row, out_item.matched_row);
                        error_count++;
                    end
                end
            end
        end
    end

    // Driver: inputs change only at the falling edge. A new byte is offered
    // once the previous one was taken, unless the sender chooses to idle.
    // The receiver stalls at random with its own rate.
    always @(negedge clk)
    begin
        path_item_t item;
        if (!rst_n)
        begin
            in_item.valid     <= 1'b0;
            in_item.path_byte <= 8'h00;
            in_item.last_byte <= 1'b0;
            out_item.ready    <= 1'b0;
        end
        else
        begin
            if (!in_item.valid || byte_taken)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    item = pending_bytes.pop_front();
                    in_item.valid     <= 1'b1;
                    in_item.path_byte <= item.value;
                    in_item.last_byte <= item.last;
                end
                else
                    in_item.valid <= 1'b0;
            end
            out_item.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned gap_by_phase [4];
        int unsigned stall_by_phase [4];
        gap_by_phase   = '{0, 50, 0, 15};
        stall_by_phase = '{0, 0, 50, 15};

        gap_pct            = 0;
        stall_pct          = 0;
        queued_bytes       = 0;
        queued_paths       = 0;
        load_needles();
        clear_path_state();

        // Directed paths: a lone zero byte is an empty path; a lone 0xFF byte
        // matches nothing; an earlier row beats a later one found first; an
        // upper-case path hits a folded row; the bytes after a zero are not
        // looked at, although the marked byte after them still ends the path.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_text("/root/tmp/");
        queue_text("\\USERS\\");
        for (int i = 0; i < 5; i++)
            queue_byte(byte'("/opt/" >> (8 * (4 - i))), 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_text("/tmp/");

        for (int phase = 0; phase < 4; phase++)
        begin
            gap_pct      = gap_by_phase[phase];
            stall_pct    = stall_by_phase[phase];
            queued_bytes = 0;
            queued_paths = 0;
            while (queued_bytes < PHASE_BYTES || queued_paths < PHASE_PATHS)
                queue_random_path();
            while (pending_bytes.size() != 0)
                @(negedge clk);
        end

        // Let the last byte go in and every expected class come out, then
        // keep watching for anything extra.
        while (in_item.valid || expected_classes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
